FILE: sv/dks_pkg.sv
package dks_pkg;

  localparam int HALF_W    = 28;
  localparam int KEY_W     = 64;
  localparam int PERM_W    = 56;
  localparam int SUB_W     = 48;
  localparam int LEN_W     = 4;
  localparam int ROUND_W   = 4;
  localparam int RNUM_W    = 5;
  localparam int NUM_ROUNDS = 16;
  localparam int KEY_BYTES  = 8;

  localparam int DEF_QUEUE_DEPTH = 2;
  localparam int DEF_OUT_DEPTH   = 2;

  localparam logic [ROUND_W-1:0] FIRST_ROUND = '0;
  localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(NUM_ROUNDS - 1);

  localparam logic [6:0] PC1_TAB [PERM_W] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
    7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
    7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [SUB_W] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [1:0] ROT_TAB [NUM_ROUNDS] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  typedef struct packed {
    logic [HALF_W-1:0] c;
    logic [HALF_W-1:0] d;
    logic              rev;
  } half_word_t;

  typedef struct packed {
    logic [SUB_W-1:0]  subkey;
    logic [RNUM_W-1:0] round_number;
    logic              last;
  } sub_word_t;

  function automatic logic [KEY_W-1:0] pad_key(input logic [KEY_W-1:0] key,
                                               input logic [LEN_W-1:0] len_in);
    logic [LEN_W-1:0] len;
    logic [7:0]       padv;
    logic [KEY_W-1:0] res;
    len  = (len_in > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : len_in;
    padv = 8'(LEN_W'(KEY_BYTES) - len);
    res  = key;
    for (int k = 0; k < KEY_BYTES; k++) begin
      if (k >= int'(len)) begin
        res[KEY_W-1-8*k -: 8] = padv;
      end
    end
    return res;
  endfunction

  function automatic logic [PERM_W-1:0] pc1(input logic [KEY_W-1:0] key);
    logic [PERM_W-1:0] r;
    r = '0;
    for (int i = 0; i < PERM_W; i++) begin
      r[PERM_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [SUB_W-1:0] pc2(input logic [HALF_W-1:0] c,
                                           input logic [HALF_W-1:0] d);
    logic [PERM_W-1:0] cd;
    logic [SUB_W-1:0]  r;
    cd = {c, d};
    r  = '0;
    for (int j = 0; j < SUB_W; j++) begin
      r[SUB_W-1-j] = cd[PERM_W - int'(PC2_TAB[j])];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] rotl(input logic [HALF_W-1:0] v,
                                             input logic [1:0] n);
    return (n == 2'd2) ? {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]}
                       : {v[HALF_W-2:0], v[HALF_W-1]};
  endfunction

  function automatic logic [HALF_W-1:0] rotr(input logic [HALF_W-1:0] v,
                                             input logic [1:0] n);
    return (n == 2'd2) ? {v[1:0], v[HALF_W-1:2]}
                       : {v[0], v[HALF_W-1:1]};
  endfunction

endpackage

FILE: sv/dks_fifo.sv
module dks_fifo
  import dks_pkg::*;
#(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/dks_front.sv
module dks_front
  import dks_pkg::*;
(
  input  logic [KEY_W-1:0] key_bytes_i,
  input  logic [LEN_W-1:0] key_length_i,
  input  logic             reverse_order_i,
  output half_word_t       word_o
);

  logic [KEY_W-1:0]  padded;
  logic [PERM_W-1:0] perm;

  assign padded = pad_key(key_bytes_i, key_length_i);
  assign perm   = pc1(padded);

  assign word_o.c   = perm[PERM_W-1:HALF_W];
  assign word_o.d   = perm[HALF_W-1:0];
  assign word_o.rev = reverse_order_i;

endmodule

FILE: sv/dks_back.sv
module dks_back
  import dks_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  half_word_t in_word_i,
  output logic       in_pop_o,
  input  logic       out_full_i,
  output logic       out_push_o,
  output sub_word_t  out_word_o
);

  logic                busy_q, busy_d;
  logic                rev_q, rev_d;
  logic [ROUND_W-1:0]  round_q, round_d;
  logic [HALF_W-1:0]   c_q, c_d;
  logic [HALF_W-1:0]   d_q, d_d;
  logic                step, is_last, load;
  logic [ROUND_W-1:0]  round_up, round_dn;

  assign step     = busy_q && !out_full_i;
  assign is_last  = rev_q ? (round_q == FIRST_ROUND) : (round_q == LAST_ROUND);
  assign load     = in_valid_i && (!busy_q || (step && is_last));
  assign round_up = round_q + 1'b1;
  assign round_dn = round_q - 1'b1;

  assign in_pop_o                = load;
  assign out_push_o              = step;
  assign out_word_o.subkey       = pc2(c_q, d_q);
  assign out_word_o.round_number = RNUM_W'(round_q) + 1'b1;
  assign out_word_o.last         = is_last;

  always_comb begin
    busy_d  = busy_q;
    rev_d   = rev_q;
    round_d = round_q;
    c_d     = c_q;
    d_d     = d_q;
    if (load) begin
      busy_d = 1'b1;
      rev_d  = in_word_i.rev;
      if (in_word_i.rev) begin
        round_d = LAST_ROUND;
        c_d     = in_word_i.c;
        d_d     = in_word_i.d;
      end else begin
        round_d = FIRST_ROUND;
        c_d     = rotl(in_word_i.c, ROT_TAB[FIRST_ROUND]);
        d_d     = rotl(in_word_i.d, ROT_TAB[FIRST_ROUND]);
      end
    end else if (step) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else if (rev_q) begin
        round_d = round_dn;
        c_d     = rotr(c_q, ROT_TAB[round_q]);
        d_d     = rotr(d_q, ROT_TAB[round_q]);
      end else begin
        round_d = round_up;
        c_d     = rotl(c_q, ROT_TAB[round_up]);
        d_d     = rotl(d_q, ROT_TAB[round_up]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rev_q   <= 1'b0;
      round_q <= '0;
    end else begin
      busy_q  <= busy_d;
      rev_q   <= rev_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    d_q <= d_d;
  end

endmodule

FILE: sv/des_key_schedule.sv
// DES key schedule.
// Input channel: drive key_bytes_i, key_length_i and reverse_order_i with push
// high; the word is taken at a clock edge where push is high and full is low.
// Output channel: while empty is low, subkey_o, round_number_o and last_o show
// the oldest subkey; it is taken at an edge where pop is high and empty is low.
// Each key yields sixteen subkeys, rounds 1..16, or 16..1 when reverse_order_i
// is set; last_o marks the sixteenth.
// A taken key goes into the key queue, then into the sequencer registers if the
// block is idle; its first subkey then goes into the output queue. Throughput:
// one subkey per cycle while the output queue is not full, from the single round
// sequencer stepping one round a cycle. Pad and PC-1 work in the front; a key
// queue (QueueDepth words) lets the next key be taken while the sequencer runs.
// When the receiver holds pop low, the output queue (OutDepth words) fills,
// the sequencer holds, and then the key queue fills and full rises.
// Reset empties both queues and idles the sequencer; no pass over storage.
module des_key_schedule
  import dks_pkg::*;
#(
  parameter int QueueDepth = DEF_QUEUE_DEPTH,
  parameter int OutDepth   = DEF_OUT_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [KEY_W-1:0]  key_bytes_i,
  input  logic [LEN_W-1:0]  key_length_i,
  input  logic              reverse_order_i,
  output logic              empty,
  input  logic              pop,
  output logic [SUB_W-1:0]  subkey_o,
  output logic [RNUM_W-1:0] round_number_o,
  output logic              last_o
);

  half_word_t front_word, queue_word;
  sub_word_t  back_word, out_word;
  logic       queue_empty, queue_pop;
  logic       out_full, out_push;

  dks_front u_front (
    .key_bytes_i     (key_bytes_i),
    .key_length_i    (key_length_i),
    .reverse_order_i (reverse_order_i),
    .word_o          (front_word)
  );

  dks_fifo #(
    .Width ($bits(half_word_t)),
    .Depth (QueueDepth)
  ) u_key_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_word),
    .full_o  (full),
    .pop_i   (queue_pop),
    .rdata_o (queue_word),
    .empty_o (queue_empty)
  );

  dks_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!queue_empty),
    .in_word_i  (queue_word),
    .in_pop_o   (queue_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_word_o (back_word)
  );

  dks_fifo #(
    .Width ($bits(sub_word_t)),
    .Depth (OutDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_word),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_word),
    .empty_o (empty)
  );

  assign subkey_o       = out_word.subkey;
  assign round_number_o = out_word.round_number;
  assign last_o         = out_word.last;

endmodule
